>>> rtl/mpt_pkg.sv
`default_nettype none
package mpt_pkg;

  localparam int CHANNELS_DEF    = 9;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int LEVEL_W    = 9;
  localparam int MASK_W     = 9;
  localparam int ACTION_W   = 3;
  localparam int CHANNEL_W  = 4;
  localparam int STEPS_W    = 16;
  localparam int OFFSET_W   = 8;
  localparam int S_TDATA_W  = 56;
  localparam int S_TUSER_W  = 4;
  localparam int M_TDATA_W  = 16;

  localparam logic [MASK_W-1:0] FULL_MASK = '1;

  localparam logic [7:0] LED_ON  = 8'd130;
  localparam logic [7:0] LED_OFF = 8'd26;
  localparam logic [7:0] PUMP_ON  [8] = '{8'd108, 8'd106, 8'd106, 8'd108,
                                          8'd106, 8'd101, 8'd104, 8'd98};
  localparam logic [7:0] PUMP_OFF [8] = '{8'd48, 8'd50, 8'd50, 8'd48,
                                          8'd50, 8'd55, 8'd52, 8'd58};

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 3'd0,
    ACT_WRITE_TIMING = 3'd1,
    ACT_WRITE_OFFSET = 3'd2,
    ACT_ENABLE       = 3'd3,
    ACT_DISABLE      = 3'd4,
    ACT_SYNC         = 3'd5
  } action_t;

  typedef struct packed {
    logic start;
    logic step;
    logic apply;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  function automatic logic is_full(input logic [ACTION_W-1:0] action,
                                   input logic [MASK_W-1:0] mask,
                                   input logic reset_all);
    return reset_all || (action == ACT_SYNC && mask == FULL_MASK);
  endfunction

  function automatic logic [7:0] def_on(input int unsigned n, input int unsigned chans);
    if (n == chans - 1) begin
      return LED_ON;
    end
    return PUMP_ON[n & 7];
  endfunction

  function automatic logic [7:0] def_off(input int unsigned n, input int unsigned chans);
    if (n == chans - 1) begin
      return LED_OFF;
    end
    return PUMP_OFF[n & 7];
  endfunction

endpackage
`default_nettype wire

>>> rtl/mpt_ctrl.sv
`default_nettype none
module mpt_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [mpt_pkg::ACTION_W-1:0]      action,
  input  wire logic [mpt_pkg::MASK_W-1:0]        channel_mask,
  input  wire logic                              reset_all,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output mpt_pkg::dp_cmd_t                       cmd,
  input  wire mpt_pkg::dp_stat_t                 stat
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t state;
  logic   accept;
  logic   is_tick;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_tick  = !mpt_pkg::is_full(action, channel_mask, reset_all) &&
                    (action == mpt_pkg::ACT_TICK);

  always_comb begin
    cmd.start = accept && is_tick;
    cmd.step  = (state == S_WALK);
    cmd.apply = accept;
    cmd.load  = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= is_tick ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          if (stat.last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    accept && is_tick |=> state == S_WALK)
    else $error("tick beat did not start a channel walk");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && stat.last |=> state == S_DONE)
    else $error("walk did not finish after last channel");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !m_tvalid |=> m_tvalid)
    else $error("result not loaded into free output register");

endmodule
`default_nettype wire

>>> rtl/mpt_dp.sv
`default_nettype none
module mpt_dp #(
  parameter int CHANNELS    = mpt_pkg::CHANNELS_DEF,
  parameter int COUNT_WIDTH = mpt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire mpt_pkg::dp_cmd_t                      cmd,
  output mpt_pkg::dp_stat_t                          stat,
  input  wire logic [mpt_pkg::ACTION_W-1:0]          action,
  input  wire logic [mpt_pkg::CHANNEL_W-1:0]         channel,
  input  wire logic [mpt_pkg::MASK_W-1:0]            channel_mask,
  input  wire logic [mpt_pkg::STEPS_W-1:0]           on_steps,
  input  wire logic [mpt_pkg::STEPS_W-1:0]           off_steps,
  input  wire logic signed [mpt_pkg::OFFSET_W-1:0]   offset_value,
  input  wire logic                                  reset_all,
  output logic [mpt_pkg::LEVEL_W-1:0]                levels
);

  localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VIS = (CHANNELS < mpt_pkg::LEVEL_W) ? CHANNELS : mpt_pkg::LEVEL_W;

  logic [COUNT_WIDTH-1:0]       tick_count   [CHANNELS];
  logic [COUNT_WIDTH-1:0]       on_length    [CHANNELS];
  logic [COUNT_WIDTH-1:0]       off_length   [CHANNELS];
  logic [mpt_pkg::OFFSET_W-1:0] shift_offset [CHANNELS];
  logic [CHANNELS-1:0]          enabled;
  logic [CHANNELS-1:0]          level;
  logic [IW-1:0]                idx;

  logic [IW-1:0]                ch_sel;
  logic [CHANNELS-1:0]          mask_sel;
  logic                         full;
  logic                         full_apply;
  mpt_pkg::action_t             act;
  logic [COUNT_WIDTH-1:0]       cnt_inc;
  logic [COUNT_WIDTH-1:0]       on_thr;
  logic                         go_low;
  logic                         go_high;
  logic [mpt_pkg::LEVEL_W-1:0]  levels_now;

  always_comb begin
    act        = mpt_pkg::action_t'(action);
    full       = mpt_pkg::is_full(action, channel_mask, reset_all);
    full_apply = cmd.apply && full;
    ch_sel     = (32'(channel) >= CHANNELS) ? IW'(CHANNELS - 1) : IW'(channel);
    mask_sel   = CHANNELS'(channel_mask[VIS-1:0]);
    cnt_inc    = tick_count[idx] + 1'b1;
    on_thr     = on_length[idx] + COUNT_WIDTH'($signed(shift_offset[idx]));
    go_low     = level[idx] && (cnt_inc >= off_length[idx]);
    go_high    = !level[idx] && (cnt_inc >= on_thr);
    levels_now = mpt_pkg::LEVEL_W'(level[VIS-1:0]);
    stat.last  = (idx == IW'(CHANNELS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst || full_apply) begin
      for (int n = 0; n < CHANNELS; n++) begin
        on_length[n]    <= COUNT_WIDTH'(mpt_pkg::def_on(n, CHANNELS));
        off_length[n]   <= COUNT_WIDTH'(mpt_pkg::def_off(n, CHANNELS));
        shift_offset[n] <= '0;
        tick_count[n]   <= '0;
      end
      level <= '0;
    end else if (cmd.apply) begin
      case (act)
        mpt_pkg::ACT_WRITE_TIMING: begin
          on_length[ch_sel]  <= COUNT_WIDTH'(on_steps);
          off_length[ch_sel] <= COUNT_WIDTH'(off_steps);
        end
        mpt_pkg::ACT_WRITE_OFFSET: begin
          shift_offset[ch_sel] <= offset_value;
        end
        mpt_pkg::ACT_DISABLE: begin
          level <= level & ~mask_sel;
        end
        mpt_pkg::ACT_SYNC: begin
          level <= level & ~mask_sel;
          for (int n = 0; n < CHANNELS; n++) begin
            if (mask_sel[n]) begin
              tick_count[n] <= '0;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.step && enabled[idx]) begin
      if (go_low) begin
        level[idx]      <= 1'b0;
        tick_count[idx] <= '0;
      end else if (go_high) begin
        level[idx]      <= 1'b1;
        tick_count[idx] <= '0;
      end else begin
        tick_count[idx] <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else if (cmd.apply && !full) begin
      case (act)
        mpt_pkg::ACT_ENABLE:  enabled <= enabled | mask_sel;
        mpt_pkg::ACT_DISABLE: enabled <= enabled & ~mask_sel;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.start) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      levels <= levels_now;
    end
  end

  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.apply)
    else $error("channel walk overlaps an accepted beat");

  a_full_low: assert property (@(posedge clk) disable iff (rst)
    full_apply |=> level == '0)
    else $error("full reset left a channel high");

  a_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> levels == $past(levels_now))
    else $error("output register does not hold loaded levels");

endmodule
`default_nettype wire

>>> rtl/multichannel_pulse_timer.sv
// A non-tick beat is applied when accepted, and its levels are then loaded into
// the output register once it is free; a tick beat first walks the channel bank
// one channel per cycle. No new beat is accepted until the result is loaded.
// The output register frees the input side while a result waits downstream.
// Reset (rst, synchronous): default timings, zero offsets and counters,
// all channels disabled and low, no result pending.
`default_nettype none
module multichannel_pulse_timer #(
  parameter int CHANNELS    = mpt_pkg::CHANNELS_DEF,
  parameter int COUNT_WIDTH = mpt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // channel[3:0], channel_mask[12:4], on_steps[28:13], off_steps[44:29],
  // offset_value[52:45], zero pad [55:53]
  input  wire logic [mpt_pkg::S_TDATA_W-1:0]    s_tdata,
  // action[2:0], reset_all[3]
  input  wire logic [mpt_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // levels[8:0], zero pad [15:9]
  output logic [mpt_pkg::M_TDATA_W-1:0]         m_tdata
);

  mpt_pkg::dp_cmd_t            cmd;
  mpt_pkg::dp_stat_t           stat;
  logic [mpt_pkg::LEVEL_W-1:0] levels;

  mpt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .action       (s_tuser[2:0]),
    .channel_mask (s_tdata[12:4]),
    .reset_all    (s_tuser[3]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cmd          (cmd),
    .stat         (stat)
  );

  mpt_dp #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (s_tuser[2:0]),
    .channel      (s_tdata[3:0]),
    .channel_mask (s_tdata[12:4]),
    .on_steps     (s_tdata[28:13]),
    .off_steps    (s_tdata[44:29]),
    .offset_value (s_tdata[52:45]),
    .reset_all    (s_tuser[3]),
    .levels       (levels)
  );

  assign m_tdata = mpt_pkg::M_TDATA_W'(levels);

endmodule
`default_nettype wire
